[sv/u8dec_pkg.sv]
// Shared types and constants for the UTF-8 stream decoder and classifier.
`default_nettype none
package u8dec_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned CpWidth     = 21;
   localparam int unsigned LenWidth    = 3;
   localparam int unsigned StatusWidth = 2;
   localparam int unsigned ClassWidth  = 3;
   localparam int unsigned PendWidth   = 2;

   typedef logic [ByteWidth-1:0]   byte_type;
   typedef logic [CpWidth-1:0]     cp_type;
   typedef logic [LenWidth-1:0]    len_type;
   typedef logic [StatusWidth-1:0] status_type;
   typedef logic [ClassWidth-1:0]  class_type;
   typedef logic [PendWidth-1:0]   pend_type;

   localparam status_type ST_OK         = 2'd0;
   localparam status_type ST_STRAY_CONT = 2'd1;
   localparam status_type ST_BAD_LEAD   = 2'd2;
   localparam status_type ST_BROKEN     = 2'd3;

   localparam class_type CL_OTHER = 3'd0;
   localparam class_type CL_LOWER = 3'd1;
   localparam class_type CL_UPPER = 3'd2;
   localparam class_type CL_DIGIT = 3'd3;
   localparam class_type CL_SIGN  = 3'd4;
   localparam class_type CL_SPACE = 3'd5;
   localparam class_type CL_EOL   = 3'd6;

   localparam byte_type CONT_PAYLOAD_MASK = 8'h3f;
   localparam logic [1:0] CONT_TAG        = 2'b10;

   typedef struct packed {
      cp_type   partial_value;
      pend_type bytes_pending;
      len_type  rune_total_length;
   } rune_state_type;

   typedef struct packed {
      cp_type     code_point;
      len_type    rune_bytes;
      status_type status;
      class_type  char_class;
   } result_type;

endpackage
`default_nettype wire

[sv/u8dec_if.sv]
// Valid/ready channel interfaces for the byte input and the rune result.
`default_nettype none
interface u8dec_req_if;
   logic                 valid;
   logic                 ready;
   u8dec_pkg::byte_type  byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

interface u8dec_rsp_if;
   logic                  valid;
   logic                  ready;
   u8dec_pkg::cp_type     code_point;
   u8dec_pkg::len_type    rune_bytes;
   u8dec_pkg::status_type status;
   u8dec_pkg::class_type  char_class;

   modport source (output valid, output code_point, output rune_bytes,
                   output status, output char_class, input ready);
   modport sink   (input valid, input code_point, input rune_bytes,
                   input status, input char_class, output ready);
endinterface
`default_nettype wire

[sv/u8dec_decode.sv]
// Combinational next-state and result logic for one input byte.
`default_nettype none
module u8dec_decode (
   input  wire u8dec_pkg::byte_type       byte_in,
   input  wire u8dec_pkg::rune_state_type state_cur,
   output u8dec_pkg::rune_state_type      state_nxt,
   output logic                           emit,
   output u8dec_pkg::result_type          result
);
   import u8dec_pkg::*;

   logic       is_cont;
   cp_type     shifted;
   pend_type   pend_dec;
   cp_type     cp;
   len_type    len;
   status_type st;
   class_type  cls;

   assign is_cont  = (byte_in[7:6] == CONT_TAG);
   assign shifted  = {state_cur.partial_value[CpWidth-7:0],
                      byte_in[5:0] & CONT_PAYLOAD_MASK[5:0]};
   assign pend_dec = state_cur.bytes_pending - 2'd1;

   always_comb begin
      state_nxt = state_cur;
      emit      = 1'b0;
      cp        = '0;
      len       = '0;
      st        = ST_OK;
      if (state_cur.bytes_pending != '0) begin
         if (!is_cont) begin
            state_nxt = '0;
            emit      = 1'b1;
            st        = ST_BROKEN;
         end else if (pend_dec == '0) begin
            state_nxt = '0;
            emit      = 1'b1;
            cp        = shifted;
            len       = state_cur.rune_total_length;
         end else begin
            state_nxt.partial_value = shifted;
            state_nxt.bytes_pending = pend_dec;
         end
      end else begin
         unique casez (byte_in)
            8'b0???????: begin
               emit = 1'b1;
               cp   = {{(CpWidth-ByteWidth){1'b0}}, byte_in};
               len  = 3'd1;
            end
            8'b10??????: begin
               emit = 1'b1;
               st   = ST_STRAY_CONT;
            end
            8'b110?????: begin
               state_nxt.partial_value     = {16'd0, byte_in[4:0]};
               state_nxt.bytes_pending     = 2'd1;
               state_nxt.rune_total_length = 3'd2;
            end
            8'b1110????: begin
               state_nxt.partial_value     = {17'd0, byte_in[3:0]};
               state_nxt.bytes_pending     = 2'd2;
               state_nxt.rune_total_length = 3'd3;
            end
            8'b11110???: begin
               state_nxt.partial_value     = {18'd0, byte_in[2:0]};
               state_nxt.bytes_pending     = 2'd3;
               state_nxt.rune_total_length = 3'd4;
            end
            default: begin
               emit = 1'b1;
               st   = ST_BAD_LEAD;
            end
         endcase
      end
   end

   always_comb begin
      priority if (st != ST_OK)
         cls = CL_OTHER;
      else if (cp >= 21'd97 && cp <= 21'd122)
         cls = CL_LOWER;
      else if (cp >= 21'd65 && cp <= 21'd90)
         cls = CL_UPPER;
      else if (cp >= 21'd48 && cp <= 21'd57)
         cls = CL_DIGIT;
      else if (cp >= 21'd33 && cp <= 21'd126)
         cls = CL_SIGN;
      else if (cp == 21'd32 || cp == 21'd9)
         cls = CL_SPACE;
      else if (cp == 21'd13 || cp == 21'd10)
         cls = CL_EOL;
      else
         cls = CL_OTHER;
   end

   assign result = '{code_point: cp, rune_bytes: len, status: st, char_class: cls};

endmodule
`default_nettype wire

[sv/utf8_stream_decoder_classifier_core.sv]
// Bytes pass the input register, decode and classification, then the result register.
// Throughput: one byte per cycle while the result register is not stalled.
// Bytes that only extend a rune update the rune state and produce no result.
// A stalled result register holds and backpressures the input register.
// Synchronous active-high reset clears the rune state and both valid flags.
`default_nettype none
module utf8_stream_decoder_classifier_core (
   input  wire         clock,
   input  wire         reset,
   u8dec_req_if.sink   req_bus,
   u8dec_rsp_if.source rsp_bus
);
   import u8dec_pkg::*;

   logic           in_valid_ff, in_valid_in;
   byte_type       in_byte_ff, in_byte_in;
   rune_state_type state_ff, state_in;
   logic           out_valid_ff, out_valid_in;
   result_type     out_data_ff, out_data_in;

   rune_state_type dec_state;
   logic           dec_emit;
   result_type     dec_result;
   logic           advance;
   logic           in_take;

   u8dec_decode u_decode (
      .byte_in   (in_byte_ff),
      .state_cur (state_ff),
      .state_nxt (dec_state),
      .emit      (dec_emit),
      .result    (dec_result)
   );

   assign advance         = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready   = !in_valid_ff || advance;
   assign in_take         = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in  = in_take || (in_valid_ff && !advance);
      in_byte_in   = in_take ? req_bus.byte_in : in_byte_ff;
      state_in     = advance ? dec_state : state_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_data_in  = out_data_ff;
      if (advance && dec_emit) begin
         out_valid_in = 1'b1;
         out_data_in  = dec_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
      in_byte_ff  <= in_byte_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.code_point = out_data_ff.code_point;
   assign rsp_bus.rune_bytes = out_data_ff.rune_bytes;
   assign rsp_bus.status     = out_data_ff.status;
   assign rsp_bus.char_class = out_data_ff.char_class;

   a_idle_state_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff.bytes_pending == '0 |->
         (state_ff.partial_value == '0 && state_ff.rune_total_length == '0))
      else $error("rune state not cleared while no continuation is due");

   a_pending_below_total: assert property (@(posedge clock) disable iff (reset)
      state_ff.bytes_pending != '0 |->
         ({1'b0, state_ff.bytes_pending} < state_ff.rune_total_length &&
          state_ff.rune_total_length <= 3'd4))
      else $error("pending count inconsistent with rune length");

   a_error_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.status != ST_OK) |->
         (out_data_ff.code_point == '0 && out_data_ff.rune_bytes == '0 &&
          out_data_ff.char_class == CL_OTHER))
      else $error("error result carries nonzero fields");

   a_ok_length: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.status == ST_OK) |->
         (out_data_ff.rune_bytes != '0 && out_data_ff.rune_bytes <= 3'd4))
      else $error("good rune with bad length");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_bus.ready) |=> (out_valid_ff && $stable(out_data_ff)))
      else $error("pending result overwritten");

endmodule
`default_nettype wire

[test/u8dec_checker.sv]
// Checker for the UTF-8 decoder: predicts each rune result and compares it on the response channel.
module u8dec_checker (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  wire                   req_ready,
   input  u8dec_pkg::byte_type   req_byte_in,
   input  wire                   rsp_valid,
   input  wire                   rsp_ready,
   input  u8dec_pkg::cp_type     rsp_code_point,
   input  u8dec_pkg::len_type    rsp_rune_bytes,
   input  u8dec_pkg::status_type rsp_status,
   input  u8dec_pkg::class_type  rsp_char_class,
   output int                    mismatches,
   output int                    outstanding,
   output int                    bytes_seen,
   output int                    runes_seen,
   output int                    faults_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import u8dec_pkg::*;

   cp_type     rune_acc;
   pend_type   rune_left;
   len_type    rune_len;
   result_type expected_runes[$];
   result_type want;
   result_type got;
   result_type next_rune;

   function automatic class_type ascii_class(input cp_type cp);
      if (cp >= "a" && cp <= "z") return CL_LOWER;
      if (cp >= "A" && cp <= "Z") return CL_UPPER;
      if (cp >= "0" && cp <= "9") return CL_DIGIT;
      if (cp >= "!" && cp <= "~") return CL_SIGN;
      if (cp == " " || cp == 21'h09) return CL_SPACE;
      if (cp == 21'h0d || cp == 21'h0a) return CL_EOL;
      return CL_OTHER;
   endfunction

   function automatic void drop_rune();
      rune_acc  = '0;
      rune_left = '0;
      rune_len  = '0;
   endfunction

   // returns 1 when the byte completes a rune or raises an error
   function automatic bit decode_byte(input byte_type b, output result_type r);
      r = '0;
      if (rune_left != 0) begin
         if (b[7:6] != CONT_TAG) begin
            drop_rune();
            r.status = ST_BROKEN;
            return 1'b1;
         end
         rune_acc  = {rune_acc[CpWidth-7:0], b[5:0]};
         rune_left = rune_left - 1'b1;
         if (rune_left != 0) return 1'b0;
         r.code_point = rune_acc;
         r.rune_bytes = rune_len;
         r.status     = ST_OK;
         r.char_class = ascii_class(rune_acc);
         drop_rune();
         return 1'b1;
      end
      if (!b[7]) begin
         r.code_point = cp_type'(b);
         r.rune_bytes = 3'd1;
         r.status     = ST_OK;
         r.char_class = ascii_class(cp_type'(b));
         return 1'b1;
      end
      if (b[7:6] == CONT_TAG) begin
         r.status = ST_STRAY_CONT;
         return 1'b1;
      end
      if (b[7:5] == 3'b110) begin
         rune_acc  = cp_type'(b[4:0]);
         rune_left = 2'd1;
         rune_len  = 3'd2;
         return 1'b0;
      end
      if (b[7:4] == 4'b1110) begin
         rune_acc  = cp_type'(b[3:0]);
         rune_left = 2'd2;
         rune_len  = 3'd3;
         return 1'b0;
      end
      if (b[7:3] == 5'b11110) begin
         rune_acc  = cp_type'(b[2:0]);
         rune_left = 2'd3;
         rune_len  = 3'd4;
         return 1'b0;
      end
      r.status = ST_BAD_LEAD;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         drop_rune();
         expected_runes.delete();
         mismatches  <= 0;
         outstanding <= 0;
         bytes_seen  <= 0;
         runes_seen  <= 0;
         faults_seen <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_code_point, rsp_rune_bytes, rsp_status, rsp_char_class};
            if (got.status == ST_OK) runes_seen <= runes_seen + 1;
            else faults_seen <= faults_seen + 1;
            if (expected_runes.size() == 0) begin
               $display("%0t: unexpected result: expected none, got cp=%h len=%0d st=%0d cls=%0d",
                        $time, got.code_point, got.rune_bytes, got.status, got.char_class);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_runes.pop_front();
               if (got.code_point != want.code_point || got.rune_bytes != want.rune_bytes ||
                   got.status != want.status || got.char_class != want.char_class) begin
                  $display("%0t: mismatch: expected cp=%h len=%0d st=%0d cls=%0d,",
                           $time, want.code_point, want.rune_bytes, want.status,
                           want.char_class);
                  $display("   got cp=%h len=%0d st=%0d cls=%0d",
                           got.code_point, got.rune_bytes, got.status, got.char_class);
                  mismatches <= mismatches + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            bytes_seen <= bytes_seen + 1;
            if (decode_byte(req_byte_in, next_rune)) expected_runes.push_back(next_rune);
         end
         outstanding <= expected_runes.size();
      end
   end

endmodule

[test/tb.sv]
// Testbench top for the UTF-8 decoder: clock, reset, byte stimulus, result back-pressure and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import u8dec_pkg::*;

   localparam logic [2:0] LEAD2_TAG = 3'b110;
   localparam logic [3:0] LEAD3_TAG = 4'b1110;
   localparam logic [4:0] LEAD4_TAG = 5'b11110;
   localparam int unsigned RANDOM_BYTES = 700;

   logic clock = 1'b0;
   logic reset;

   u8dec_req_if req_bus ();
   u8dec_rsp_if rsp_bus ();

   int mismatches;
   int outstanding;
   int bytes_seen;
   int runes_seen;
   int faults_seen;

   int unsigned sent_bytes = 0;
   bit src_gaps = 1'b1;
   bit snk_stalls = 1'b1;

   utf8_stream_decoder_classifier_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   u8dec_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_byte_in    (req_bus.byte_in),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_code_point (rsp_bus.code_point),
      .rsp_rune_bytes (rsp_bus.rune_bytes),
      .rsp_status     (rsp_bus.status),
      .rsp_char_class (rsp_bus.char_class),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .bytes_seen     (bytes_seen),
      .runes_seen     (runes_seen),
      .faults_seen    (faults_seen)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic idle_gap(input int unsigned cycles);
      req_bus.valid   <= 1'b0;
      req_bus.byte_in <= byte_type'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic push_byte(input byte_type b);
      if (src_gaps && $urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 11));
      req_bus.valid   <= 1'b1;
      req_bus.byte_in <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent_bytes++;
   endtask

   // lead byte of a total-byte rune followed by conts continuation bytes
   task automatic send_rune(input int unsigned total, input int unsigned conts);
      byte_type lead;
      unique case (total)
         2: lead = {LEAD2_TAG, 5'($urandom)};
         3: lead = {LEAD3_TAG, 4'($urandom)};
         default: lead = {LEAD4_TAG, 3'($urandom)};
      endcase
      push_byte(lead);
      repeat (conts) push_byte({CONT_TAG, 6'($urandom)});
   endtask

   task automatic send_broken();
      int unsigned total;
      byte_type    intruder;
      total    = $urandom_range(2, 4);
      intruder = byte_type'($urandom);
      if (intruder[7:6] == CONT_TAG) intruder[6] = 1'b1;
      send_rune(total, $urandom_range(0, total - 2));
      push_byte(intruder);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (snk_stalls && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   initial begin
      byte_type    directed[$];
      int unsigned base;
      int unsigned r;
      int unsigned kind;
      bit          drained;

      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.byte_in <= '0;
      directed = '{8'h00, "a", "Z", "9", "~", " ", 8'h09, 8'h0a, 8'h7f,
                   8'hc2, 8'ha9,
                   8'he2, 8'h82, 8'hac,
                   8'hf7, 8'hbf, 8'hbf, 8'hbf,
                   8'h80, 8'hf8, 8'hff,
                   8'he2, 8'h41,
                   8'hc0, 8'h80};
      drained = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) push_byte(directed[i]);
      drain();

      base = sent_bytes;
      while (sent_bytes < base + RANDOM_BYTES) begin
         r          = sent_bytes - base;
         src_gaps   = (r < 250) || (r >= 350 && r < 600);
         snk_stalls = (r < 150) || (r >= 300 && r < 600);
         kind = $urandom_range(0, 99);
         if (kind < 35) push_byte({1'b0, 7'($urandom)});
         else if (kind < 50) send_rune(2, 1);
         else if (kind < 65) send_rune(3, 2);
         else if (kind < 80) send_rune(4, 3);
         else if (kind < 90) send_broken();
         else push_byte(byte_type'($urandom));
         if (!drained && r > 400) begin
            drain();
            drained = 1'b1;
         end
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Summary: %0d bytes in, %0d runes of 1 to 4 bytes decoded, %0d error results",
               bytes_seen, runes_seen, faults_seen);
      $display("         (stray, bad lead, broken), with and without idling on both channels.");
      if (mismatches == 0 && outstanding == 0)
         $display("utf8_stream_decoder_classifier_core test passed");
      else
         $display("utf8_stream_decoder_classifier_core test failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d results still expected", outstanding);
      $display("utf8_stream_decoder_classifier_core test failed");
      $finish;
   end

endmodule
